// ===== rtl/core/waveform_envelope_pyramid_unit_assert.svh =====
// Assertion macros for the envelope pyramid unit.
// Needs clk and arst_n in the scope of each use.
`ifndef WAVEFORM_ENVELOPE_PYRAMID_UNIT_ASSERT_SVH
`define WAVEFORM_ENVELOPE_PYRAMID_UNIT_ASSERT_SVH

// cause and effect in the same cycle
`define WEP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cause, then effect in the next cycle
`define WEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wep_pkg.sv =====
// Shared types and constants of the envelope pyramid unit.
// No dependencies.
package wep_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int PEAK_W      = 17;
	localparam int LVL_W       = 5;
	localparam int FILL_W      = 16;
	localparam int JOB_DEPTH   = 4;
	localparam int RES_DEPTH   = 4;
	localparam int LEVEL_CAP   = 16;
	localparam int SHIFT_CAP   = 16;
	localparam int CHAN_CAP    = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHANNEL_TOTAL,
		REG_CHANNEL_PICK,
		REG_BASE_SHIFT,
		REG_LEVEL_TOTAL
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CASC,
		BK_FLUSH,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		logic [3:0]       total;
		logic [2:0]       pick;
		logic [4:0]       shift;
		logic [LVL_W-1:0] levels;
	} cfg_eff_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               final_req;
	} sample_item_t;

	typedef struct packed {
		logic [3:0]  level;
		logic [14:0] amplitude;
		logic        run_end;
		logic        stream_done;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ===== rtl/core/wep_fifo.sv =====
// Small synchronous queue with fall-through read of the oldest item.
// No dependencies.
module wep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/wep_front.sv =====
// Front end: channel selection and level-0 block accumulation.
// Depends on wep_pkg; hands finished blocks and flush requests on as jobs.
module wep_front #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wep_pkg::cfg_eff_t         cfg,
	input  logic                      take,
	input  wep_pkg::sample_item_t     item,
	output logic                      job_push,
	output logic                      job_blk,
	output logic                      job_fin,
	output logic [SUM_WIDTH-1:0]      job_sum,
	output logic [wep_pkg::PEAK_W-1:0] job_peak
);
	import wep_pkg::*;

	function automatic logic [2:0] pick_mod(input logic [2:0] pick, input logic [3:0] total);
		logic [3:0] r;
		r = {1'b0, pick};
		for (int i = 0; i < 7; i++) begin
			if (r >= total) begin
				r = r - total;
			end
		end
		return r[2:0];
	endfunction

	logic [SUM_WIDTH-1:0] sum0_q;
	logic [PEAK_W-1:0]    peak0_q;
	logic [FILL_W-1:0]    fill_q;
	logic [2:0]           slot_q;

	logic [2:0]           slot_eff, slot_nxt;
	logic                 sel;
	logic [15:0]          raw;
	logic [PEAK_W-1:0]    mag;
	logic [SUM_WIDTH:0]   sum_wide;
	logic [SUM_WIDTH-1:0] acc_sum;
	logic [PEAK_W-1:0]    acc_peak;
	logic [PEAK_W-1:0]    size;
	logic                 blk_done;

	assign slot_eff = ({1'b0, slot_q} >= cfg.total) ? '0 : slot_q;
	assign slot_nxt = (({1'b0, slot_eff} + 4'd1) >= cfg.total) ? '0 : slot_eff + 3'd1;
	assign sel      = (slot_eff == pick_mod(cfg.pick, cfg.total));
	assign raw      = item.sample;
	assign mag      = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	assign sum_wide = {1'b0, sum0_q} + (SUM_WIDTH + 1)'(mag);
	assign acc_sum  = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
	assign acc_peak = (mag > peak0_q) ? mag : peak0_q;
	assign size     = PEAK_W'(1) << cfg.shift;
	assign blk_done = sel && (({1'b0, fill_q} + 17'd1) >= size);

	assign job_push = take && (blk_done || item.final_req);
	assign job_blk  = blk_done;
	assign job_fin  = item.final_req;
	assign job_sum  = acc_sum;
	assign job_peak = acc_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum0_q  <= '0;
			peak0_q <= '0;
			fill_q  <= '0;
			slot_q  <= '0;
		end else if (take) begin
			if (item.final_req) begin
				sum0_q  <= '0;
				peak0_q <= '0;
				fill_q  <= '0;
				slot_q  <= '0;
			end else begin
				slot_q <= slot_nxt;
				if (blk_done) begin
					sum0_q  <= '0;
					peak0_q <= '0;
					fill_q  <= '0;
				end else if (sel) begin
					sum0_q  <= acc_sum;
					peak0_q <= acc_peak;
					fill_q  <= fill_q + FILL_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/wep_back.sv =====
// Back end: level cascade, flush walk and amplitude of each finished block.
// Depends on wep_pkg; takes jobs from the front queue, feeds the result queue.
module wep_back #(
	parameter int MAX_LEVELS = 16,
	parameter int SUM_WIDTH  = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wep_pkg::cfg_eff_t              cfg,
	input  logic                           job_valid,
	input  logic                           job_blk,
	input  logic                           job_fin,
	input  logic [SUM_WIDTH-1:0]           job_sum,
	input  logic [wep_pkg::PEAK_W-1:0]     job_peak,
	output logic                           job_pop,
	input  logic                           res_full,
	output logic                           res_push,
	output wep_pkg::result_t               res_data
);
	import wep_pkg::*;

	localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	back_state_t          state_q, state_d;
	logic [LVL_W-1:0]     lvl_q;
	logic [SUM_WIDTH-1:0] sum_q;
	logic [PEAK_W-1:0]    peak_q;
	logic                 carry_q, fin_q;
	logic [MAX_LEVELS-1:0] pend_q;
	logic [SUM_WIDTH-1:0] lsum_q  [MAX_LEVELS];
	logic [PEAK_W-1:0]    lpeak_q [MAX_LEVELS];

	logic                 hold_vld_q;
	logic [LVL_W-1:0]     hold_lvl_q;
	logic [SUM_WIDTH-1:0] hold_sum_q;
	logic [PEAK_W-1:0]    hold_peak_q;

	logic [LVL_W-1:0]     up;
	logic [IDX_W-1:0]     rd_idx;
	logic                 pend_rd;
	logic [SUM_WIDTH:0]   merge_wide;
	logic [SUM_WIDTH-1:0] merged_sum;
	logic [PEAK_W-1:0]    merged_peak;
	logic                 step_ok, in_range, casc_end;
	logic                 emit_new, finish_go;
	logic [SUM_WIDTH-1:0] new_sum;
	logic [PEAK_W-1:0]    new_peak;

	logic [5:0]           sh_amt;
	logic [SUM_WIDTH-1:0] mean_full;
	logic [15:0]          mean16;
	logic [17:0]          avg;
	logic [16:0]          half;

	assign up          = lvl_q + LVL_W'(1);
	assign rd_idx      = (state_q == BK_CASC) ? up[IDX_W-1:0] : lvl_q[IDX_W-1:0];
	assign pend_rd     = pend_q[rd_idx];
	assign merge_wide  = {1'b0, lsum_q[rd_idx]} + {1'b0, sum_q};
	assign merged_sum  = merge_wide[SUM_WIDTH] ? '1 : merge_wide[SUM_WIDTH-1:0];
	assign merged_peak = (lpeak_q[rd_idx] > peak_q) ? lpeak_q[rd_idx] : peak_q;
	assign step_ok     = !hold_vld_q || !res_full;
	assign in_range    = (lvl_q < cfg.levels);
	assign casc_end    = !in_range || (up >= cfg.levels) || !pend_rd;
	assign finish_go   = !hold_vld_q || !res_full;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					if (job_blk) begin
						state_d = BK_CASC;
					end else if (job_fin) begin
						state_d = BK_FLUSH;
					end else begin
						state_d = BK_FINISH;
					end
				end
			end
			BK_CASC: begin
				if (step_ok && casc_end) begin
					state_d = fin_q ? BK_FLUSH : BK_FINISH;
				end
			end
			BK_FLUSH: begin
				if (step_ok && !in_range) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (finish_go) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		emit_new = 1'b0;
		new_sum  = sum_q;
		new_peak = peak_q;
		case (state_q)
			BK_IDLE: begin
				job_pop = job_valid;
			end
			BK_CASC: begin
				emit_new = step_ok && in_range;
			end
			BK_FLUSH: begin
				emit_new = step_ok && in_range && (pend_rd || carry_q);
				if (pend_rd) begin
					new_sum  = carry_q ? merged_sum : lsum_q[rd_idx];
					new_peak = carry_q ? merged_peak : lpeak_q[rd_idx];
				end
			end
			default: ;
		endcase
		res_push = (emit_new && hold_vld_q) || (state_q == BK_FINISH && hold_vld_q && !res_full);
	end

	assign sh_amt    = {1'b0, cfg.shift} + {1'b0, hold_lvl_q};
	assign mean_full = hold_sum_q >> sh_amt;
	assign mean16    = (|(mean_full >> 16)) ? 16'hFFFF : mean_full[15:0];
	assign avg       = {2'b00, mean16} + {1'b0, hold_peak_q};
	assign half      = avg[17:1];

	always_comb begin
		res_data.level       = hold_lvl_q[3:0];
		res_data.amplitude   = (|half[16:15]) ? 15'h7FFF : half[14:0];
		res_data.run_end     = (state_q == BK_FINISH);
		res_data.stream_done = (state_q == BK_FINISH) && fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			lvl_q      <= '0;
			carry_q    <= 1'b0;
			fin_q      <= 1'b0;
			pend_q     <= '0;
			hold_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_new) begin
				hold_vld_q <= 1'b1;
			end else if (state_q == BK_FINISH && finish_go) begin
				hold_vld_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (job_valid) begin
						lvl_q   <= job_blk ? LVL_W'(0) : LVL_W'(1);
						fin_q   <= job_fin;
						carry_q <= 1'b0;
					end
				end
				BK_CASC: begin
					if (step_ok) begin
						if (in_range && up < cfg.levels) begin
							pend_q[rd_idx] <= !pend_rd;
						end
						if (casc_end) begin
							lvl_q   <= LVL_W'(1);
							carry_q <= 1'b0;
						end else begin
							lvl_q <= up;
						end
					end
				end
				BK_FLUSH: begin
					if (step_ok && in_range) begin
						lvl_q <= up;
						if (pend_rd) begin
							carry_q <= 1'b1;
						end
					end
				end
				BK_FINISH: begin
					if (finish_go && fin_q) begin
						pend_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_new) begin
			hold_lvl_q  <= lvl_q;
			hold_sum_q  <= new_sum;
			hold_peak_q <= new_peak;
		end
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					sum_q  <= job_sum;
					peak_q <= job_peak;
				end
			end
			BK_CASC: begin
				if (step_ok && in_range && up < cfg.levels) begin
					if (pend_rd) begin
						sum_q  <= merged_sum;
						peak_q <= merged_peak;
					end else begin
						lsum_q[rd_idx]  <= sum_q;
						lpeak_q[rd_idx] <= peak_q;
					end
				end
			end
			BK_FLUSH: begin
				if (emit_new) begin
					sum_q  <= new_sum;
					peak_q <= new_peak;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/waveform_envelope_pyramid_unit.sv =====
// Envelope pyramid unit: top level with register file and the two queues.
// Depends on wep_pkg, wep_fifo, wep_front, wep_back and the assertion header.
//
// Usage: samples go in through push/full (payload sample_item), results come out
// through empty/pop (payload result, the oldest result shown while empty is low).
// Registers are written through cfg_en/cfg_index/cfg_data with no wait state.
// The front takes one sample per cycle while its job queue has room; a sample
// that finishes no level-0 block and carries no final_req yields nothing.
// A finished block or a flush becomes a job for the back end, which walks the
// levels one per cycle while the result queue has room. The first result of a
// job passes through the job queue and the back end's hold register before it
// reaches the result queue and the outputs.
// A four-entry job queue absorbs bursts so the front keeps taking samples.
// When the receiver stalls, the four-entry result queue fills, the back end
// holds, then the job queue fills and full rises.
// Reset clears the front accumulators and the pyramid's pending flags and sets the registers to their defaults;
// no clearing pass follows, the block takes samples in the first cycle.
`include "waveform_envelope_pyramid_unit_assert.svh"

module waveform_envelope_pyramid_unit #(
	parameter int MAX_LEVELS = 16,
	parameter int SUM_WIDTH  = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  wep_pkg::sample_item_t              sample_item,
	output logic                               empty,
	input  logic                               pop,
	output wep_pkg::result_t                   result,
	input  logic                               cfg_en,
	input  logic [wep_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wep_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wep_pkg::*;

	localparam int JOB_W  = SUM_WIDTH + PEAK_W + 2;
	localparam int LV_CAP = (MAX_LEVELS > LEVEL_CAP) ? LEVEL_CAP : MAX_LEVELS;

	logic [3:0] channel_total_q;
	logic [2:0] channel_pick_q;
	logic [4:0] base_shift_q;
	logic [4:0] level_total_q;
	cfg_eff_t   cfg_eff;

	logic                 take;
	logic                 job_push, job_blk, job_fin;
	logic [SUM_WIDTH-1:0] job_sum;
	logic [PEAK_W-1:0]    job_peak;
	logic [JOB_W-1:0]     job_wdata, job_rdata;
	logic                 job_full, job_empty, job_pop;
	logic                 res_push, res_full;
	result_t              res_data;
	logic [RESULT_W-1:0]  res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_total_q <= 4'd1;
			channel_pick_q  <= 3'd0;
			base_shift_q    <= 5'd0;
			level_total_q   <= 5'd1;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHANNEL_TOTAL: channel_total_q <= cfg_data[3:0];
				REG_CHANNEL_PICK:  channel_pick_q  <= cfg_data[2:0];
				REG_BASE_SHIFT:    base_shift_q    <= cfg_data;
				REG_LEVEL_TOTAL:   level_total_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_eff.total  = (channel_total_q == 4'd0) ? 4'd1 :
			(channel_total_q > 4'(CHAN_CAP)) ? 4'(CHAN_CAP) : channel_total_q;
		cfg_eff.pick   = channel_pick_q;
		cfg_eff.shift  = (base_shift_q > 5'(SHIFT_CAP)) ? 5'(SHIFT_CAP) : base_shift_q;
		cfg_eff.levels = (level_total_q > LVL_W'(LV_CAP)) ? LVL_W'(LV_CAP) : level_total_q;
	end

	assign full = job_full;
	assign take = push && !job_full;

	wep_front #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_eff),
		.take     (take),
		.item     (sample_item),
		.job_push (job_push),
		.job_blk  (job_blk),
		.job_fin  (job_fin),
		.job_sum  (job_sum),
		.job_peak (job_peak)
	);

	assign job_wdata = {job_fin, job_blk, job_peak, job_sum};

	wep_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.pop    (job_pop),
		.wdata  (job_wdata),
		.rdata  (job_rdata),
		.full   (job_full),
		.empty  (job_empty)
	);

	wep_back #(
		.MAX_LEVELS(MAX_LEVELS),
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_eff),
		.job_valid (!job_empty),
		.job_blk   (job_rdata[JOB_W-2]),
		.job_fin   (job_rdata[JOB_W-1]),
		.job_sum   (job_rdata[SUM_WIDTH-1:0]),
		.job_peak  (job_rdata[SUM_WIDTH +: PEAK_W]),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	wep_fifo #(
		.WIDTH(RESULT_W),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.pop    (pop),
		.wdata  (res_data),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty)
	);

	assign result = result_t'(res_rdata);

	`WEP_ASSERT_SAME(a_job_room, job_push, !job_full, "job pushed into a full queue")
	`WEP_ASSERT_SAME(a_res_room, res_push, !res_full, "result pushed into a full queue")
	`WEP_ASSERT_SAME(a_res_level, res_push, ({1'b0, res_data.level} < cfg_eff.levels),
		"result level beyond the configured level count")
	`WEP_ASSERT_SAME(a_done_last, !empty && result.stream_done, result.run_end,
		"stream end flagged on a result that is not the last of its item")

endmodule
